// ===== hw/rtl/text_console_cell_writer_assert.svh =====
// Assertion macros for the text console cell writer.
// Used by the port monitor; expects i_clk and i_rst_n in scope.
`ifndef TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CELL_WRITER_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TCW_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// Shared constants, codes and controller/datapath interface types
// for the text console cell writer. No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int LIN_W   = 11;
    localparam int CH_W    = 8;
    localparam int ATTR_W  = 8;
    localparam int CELL_W  = CH_W + ATTR_W;
    localparam int COLOR_W = 4;
    localparam int KIND_W  = 2;
    localparam int CFG_IDX_W = 2;

    typedef logic [KIND_W-1:0] t_kind;
    localparam t_kind KIND_PRINT = 2'd0;
    localparam t_kind KIND_SET   = 2'd1;
    localparam t_kind KIND_READ  = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_BACKGROUND = 2'd0;
    localparam t_cfg_idx REG_FOREGROUND = 2'd1;

    localparam logic [CH_W-1:0]    CH_LF     = 8'h0A;
    localparam logic [CH_W-1:0]    CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0]    CH_BS     = 8'h08;
    localparam logic [CH_W-1:0]    CH_SPACE  = 8'h20;
    localparam logic [COLOR_W-1:0] BG_RESET  = 4'h0;
    localparam logic [COLOR_W-1:0] FG_RESET  = 4'h7;
    localparam logic [ATTR_W-1:0]  ATTR_INIT = 8'h07;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_SET,
        CUR_NEWLINE,
        CUR_BACK,
        CUR_ADV,
        CUR_UP
    } t_cur_op;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_CHAR,
        WR_BLANK_CUR,
        WR_BLANK_SWEEP,
        WR_INIT
    } t_wr_mode;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_INDEX,
        RD_COPY
    } t_rd_mode;

    typedef enum logic [2:0] {
        SW_HOLD,
        SW_ZERO,
        SW_NEXT_ROW,
        SW_LAST_ROW,
        SW_INC
    } t_sweep_op;

    typedef struct packed {
        logic      latch;
        t_cur_op   cur_op;
        t_wr_mode  wr_mode;
        t_rd_mode  rd_mode;
        logic      rd_capture;
        t_sweep_op sweep_op;
        logic      out_load;
    } t_cmd;

    typedef struct packed {
        t_kind kind;
        logic  is_newline;
        logic  is_backspace;
        logic  row_last;
        logic  lin_last;
        logic  idx_ok;
        logic  cnt_last;
        logic  init_last;
        logic  copy_last;
    } t_status;

endpackage

// ===== hw/rtl/tcw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine for the text console cell writer.
// Depends on tcw_pkg; drives tcw_datapath through t_cmd / t_status.
`timescale 1ns / 1ps

module tcw_ctrl import tcw_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_RDWAIT,
        S_WRBLANK,
        S_BLANK_ROW,
        S_SCROLL,
        S_TAIL,
        S_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_in_ready, n_in_ready;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        n_state    = r_state;
        cmd        = '{latch: 1'b0, cur_op: CUR_HOLD, wr_mode: WR_NONE, rd_mode: RD_NONE,
                       rd_capture: 1'b0, sweep_op: SW_HOLD, out_load: 1'b0};
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_INIT: begin
                cmd.wr_mode  = WR_INIT;
                cmd.sweep_op = SW_INC;
                if (i_status.init_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.kind)
                    KIND_PRINT: begin
                        if (i_status.is_newline) begin
                            cmd.cur_op = CUR_NEWLINE;
                            if (i_status.row_last) begin
                                cmd.sweep_op = SW_ZERO;
                                n_state      = S_SCROLL;
                            end else begin
                                cmd.sweep_op = SW_NEXT_ROW;
                                n_state      = S_BLANK_ROW;
                            end
                        end else if (i_status.is_backspace) begin
                            cmd.cur_op = CUR_BACK;
                            n_state    = S_WRBLANK;
                        end else begin
                            cmd.wr_mode = WR_CHAR;
                            cmd.cur_op  = CUR_ADV;
                            if (i_status.lin_last) begin
                                cmd.sweep_op = SW_ZERO;
                                n_state      = S_SCROLL;
                            end else begin
                                n_state = S_FINISH;
                            end
                        end
                    end
                    KIND_SET: begin
                        cmd.cur_op = CUR_SET;
                        n_state    = S_FINISH;
                    end
                    KIND_READ: begin
                        if (i_status.idx_ok) begin
                            cmd.rd_mode = RD_INDEX;
                        end
                        n_state = S_RDWAIT;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_RDWAIT: begin
                cmd.rd_capture = 1'b1;
                n_state        = S_FINISH;
            end
            S_WRBLANK: begin
                cmd.wr_mode = WR_BLANK_CUR;
                n_state     = S_FINISH;
            end
            S_BLANK_ROW: begin
                cmd.wr_mode  = WR_BLANK_SWEEP;
                cmd.sweep_op = SW_INC;
                if (i_status.cnt_last) begin
                    n_state = S_FINISH;
                end
            end
            S_SCROLL: begin
                cmd.rd_mode  = RD_COPY;
                cmd.sweep_op = SW_INC;
                if (i_status.copy_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                // last copy write drains this cycle
                cmd.cur_op   = CUR_UP;
                cmd.sweep_op = SW_LAST_ROW;
                n_state      = S_BLANK_ROW;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        n_in_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_in_ready  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_in_ready  <= n_in_ready;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = r_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
// Datapath: cursor, colour registers, cell store, sweep counter and result register.
// Depends on tcw_pkg and tcw_ram; commanded by tcw_ctrl.
`timescale 1ns / 1ps

module tcw_datapath import tcw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [CH_W-1:0]      i_char_code,
    input  logic [COL_W-1:0]     i_new_column,
    input  logic [ROW_W-1:0]     i_new_row,
    input  logic [LIN_W-1:0]     i_cell_index,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data,
    output logic [COL_W-1:0]     o_cursor_column,
    output logic [ROW_W-1:0]     o_cursor_row,
    output logic [LIN_W-1:0]     o_cursor_linear,
    output logic [CH_W-1:0]      o_read_char,
    output logic [ATTR_W-1:0]    o_read_attribute
);

    logic [COLOR_W-1:0] r_bg, r_fg;
    logic [COL_W-1:0]   r_col, n_col;
    logic [ROW_W-1:0]   r_row, n_row;
    logic [LIN_W-1:0]   r_lin, n_lin;
    logic [KIND_W-1:0]  r_kind;
    logic [CH_W-1:0]    r_ch;
    logic [COL_W-1:0]   r_new_col;
    logic [ROW_W-1:0]   r_new_row;
    logic [LIN_W-1:0]   r_idx;
    logic [LIN_W-1:0]   r_addr, n_addr;
    logic [COL_W-1:0]   r_cnt, n_cnt;
    logic               r_cp_pend;
    logic [LIN_W-1:0]   r_cp_addr;
    logic [CELL_W-1:0]  r_rd;
    logic [COL_W-1:0]   r_o_col;
    logic [ROW_W-1:0]   r_o_row;
    logic [LIN_W-1:0]   r_o_lin;
    logic [CELL_W-1:0]  r_o_cell;

    logic [ATTR_W-1:0]  attr;
    logic [CELL_W-1:0]  blank;
    logic [COL_W-1:0]   set_col;
    logic [ROW_W-1:0]   set_row;
    logic               ram_we, ram_re;
    logic [LIN_W-1:0]   ram_waddr, ram_raddr;
    logic [CELL_W-1:0]  ram_wdata, ram_rdata;

    assign attr  = {r_bg, r_fg};
    assign blank = {attr, CH_SPACE};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg <= BG_RESET;
            r_fg <= FG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BACKGROUND: r_bg <= i_cfg_data;
                REG_FOREGROUND: r_fg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign set_col = (r_new_col >= COL_W'(COLUMNS)) ? r_new_col - COL_W'(COLUMNS) : r_new_col;
    assign set_row = (r_new_row >= ROW_W'(ROWS)) ? r_new_row - ROW_W'(ROWS) : r_new_row;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_lin = r_lin;
        case (i_cmd.cur_op)
            CUR_SET: begin
                n_col = set_col;
                n_row = set_row;
                n_lin = LIN_W'(set_row) * LIN_W'(COLUMNS) + LIN_W'(set_col);
            end
            CUR_NEWLINE: begin
                n_col = '0;
                n_row = r_row + 1'b1;
                n_lin = r_lin - LIN_W'(r_col) + LIN_W'(COLUMNS);
            end
            CUR_BACK: begin
                if (r_lin != '0) begin
                    n_lin = r_lin - 1'b1;
                    if (r_col == '0) begin
                        n_col = COL_W'(COLUMNS - 1);
                        n_row = r_row - 1'b1;
                    end else begin
                        n_col = r_col - 1'b1;
                    end
                end
            end
            CUR_ADV: begin
                n_lin = r_lin + 1'b1;
                if (r_col == COL_W'(COLUMNS - 1)) begin
                    n_col = '0;
                    n_row = r_row + 1'b1;
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            CUR_UP: begin
                n_row = r_row - 1'b1;
                n_lin = r_lin - LIN_W'(COLUMNS);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_addr = r_addr;
        n_cnt  = r_cnt;
        case (i_cmd.sweep_op)
            SW_ZERO: begin
                n_addr = '0;
                n_cnt  = '0;
            end
            SW_NEXT_ROW: begin
                n_addr = r_lin - LIN_W'(r_col) + LIN_W'(COLUMNS);
                n_cnt  = '0;
            end
            SW_LAST_ROW: begin
                n_addr = LIN_W'(CELL_COUNT - COLUMNS);
                n_cnt  = '0;
            end
            SW_INC: begin
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_lin     <= '0;
            r_addr    <= '0;
            r_cnt     <= '0;
            r_cp_pend <= 1'b0;
        end else begin
            r_col     <= n_col;
            r_row     <= n_row;
            r_lin     <= n_lin;
            r_addr    <= n_addr;
            r_cnt     <= n_cnt;
            r_cp_pend <= (i_cmd.rd_mode == RD_COPY);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_addr;
        if (i_cmd.latch) begin
            r_kind    <= i_kind;
            r_ch      <= i_char_code;
            r_new_col <= i_new_column;
            r_new_row <= i_new_row;
            r_idx     <= i_cell_index;
            r_rd      <= '0;
        end else if (i_cmd.rd_capture) begin
            r_rd <= o_status.idx_ok ? ram_rdata : '0;
        end
        if (i_cmd.out_load) begin
            r_o_col  <= r_col;
            r_o_row  <= r_row;
            r_o_lin  <= r_lin;
            r_o_cell <= r_rd;
        end
    end

    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = r_lin;
        ram_wdata = blank;
        if (r_cp_pend) begin
            ram_waddr = r_cp_addr;
            ram_wdata = ram_rdata;
        end else begin
            case (i_cmd.wr_mode)
                WR_CHAR: begin
                    ram_wdata = {attr, r_ch};
                end
                WR_BLANK_CUR: ;
                WR_BLANK_SWEEP: begin
                    ram_waddr = r_addr;
                end
                WR_INIT: begin
                    ram_waddr = r_addr;
                    ram_wdata = {ATTR_INIT, CH_SPACE};
                end
                default: begin
                    ram_we = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        ram_re    = 1'b1;
        ram_raddr = r_idx;
        case (i_cmd.rd_mode)
            RD_INDEX: ;
            RD_COPY:  ram_raddr = r_addr + LIN_W'(COLUMNS);
            default:  ram_re = 1'b0;
        endcase
    end

    tcw_ram #(
        .WIDTH(CELL_W),
        .DEPTH(CELL_COUNT)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        o_status.kind         = r_kind;
        o_status.is_newline   = (r_ch == CH_LF) || (r_ch == CH_CR);
        o_status.is_backspace = (r_ch == CH_BS);
        o_status.row_last     = (r_row == ROW_W'(ROWS - 1));
        o_status.lin_last     = (r_lin == LIN_W'(CELL_COUNT - 1));
        o_status.idx_ok       = (r_idx < LIN_W'(CELL_COUNT));
        o_status.cnt_last     = (r_cnt == COL_W'(COLUMNS - 1));
        o_status.init_last    = (r_addr == LIN_W'(CELL_COUNT - 1));
        o_status.copy_last    = (r_addr == LIN_W'(CELL_COUNT - COLUMNS - 1));
    end

    assign o_cursor_column  = r_o_col;
    assign o_cursor_row     = r_o_row;
    assign o_cursor_linear  = r_o_lin;
    assign o_read_char      = r_o_cell[CH_W-1:0];
    assign o_read_attribute = r_o_cell[CELL_W-1:CH_W];

endmodule

// ===== hw/rtl/text_console_cell_writer.sv =====
// Text console cell writer: 80x25 cell store with a linear cursor.
// Print, cursor set or unused kind: decode, then result load; read and backspace add a state
// between; no new input is taken before the load. A newline blanks a row's 80 cells; a
// scroll copies 1920 cells through the single RAM port pair, drains the last copy write and
// blanks the last row. Reset (synchronous, active low) starts a pass that fills all 2000 cells
// with blanks of attribute 0x07; no input is accepted during it, config writes are.
`timescale 1ns / 1ps

module text_console_cell_writer import tcw_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic [CH_W-1:0]      i_char_code,
    input  logic [COL_W-1:0]     i_new_column,
    input  logic [ROW_W-1:0]     i_new_row,
    input  logic [LIN_W-1:0]     i_cell_index,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [COL_W-1:0]     o_cursor_column,
    output logic [ROW_W-1:0]     o_cursor_row,
    output logic [LIN_W-1:0]     o_cursor_linear,
    output logic [CH_W-1:0]      o_read_char,
    output logic [ATTR_W-1:0]    o_read_attribute,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COLOR_W-1:0]   i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    tcw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_kind          (i_kind),
        .i_char_code     (i_char_code),
        .i_new_column    (i_new_column),
        .i_new_row       (i_new_row),
        .i_cell_index    (i_cell_index),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_cursor_column (o_cursor_column),
        .o_cursor_row    (o_cursor_row),
        .o_cursor_linear (o_cursor_linear),
        .o_read_char     (o_read_char),
        .o_read_attribute(o_read_attribute)
    );

endmodule

// ===== hw/rtl/tcw_monitor.sv =====
// Port-level assertion monitor for text_console_cell_writer, bound to the top level.
// Depends on tcw_pkg and text_console_cell_writer_assert.svh.
`timescale 1ns / 1ps
`include "text_console_cell_writer_assert.svh"

module tcw_monitor import tcw_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic [COL_W-1:0]     o_cursor_column,
    input logic [ROW_W-1:0]     o_cursor_row,
    input logic [LIN_W-1:0]     o_cursor_linear,
    input logic [CH_W-1:0]      o_read_char,
    input logic [ATTR_W-1:0]    o_read_attribute
);

    `TCW_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_cursor_linear) && $stable(o_read_char) && $stable(o_read_attribute), "result changed while stalled")

    `TCW_ASSERT_NEXT(a_one_item, i_in_valid && o_in_ready, !o_in_ready, "second transaction taken while busy")

    `TCW_ASSERT_IMPL(a_cursor_range, o_out_valid, (o_cursor_column < COL_W'(COLUMNS)) && (o_cursor_row < ROW_W'(ROWS)), "cursor outside screen")

    `TCW_ASSERT_IMPL(a_cursor_linear, o_out_valid, o_cursor_linear == LIN_W'(o_cursor_row) * LIN_W'(COLUMNS) + LIN_W'(o_cursor_column), "linear cursor mismatch")

endmodule

bind text_console_cell_writer tcw_monitor u_monitor (.*);
